// ===== rtl/hsha_pkg.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine package
// Shared types, hash constants, controller commands and status fields.
// ----------------------------------------------------------------------------
package hsha_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic [1:0]  status;
        logic        final_word;
    } t_out_beat;

    localparam logic OP_KEY = 1'b0;
    localparam logic OP_MSG = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_KEY_LONG = 2'd1;
    localparam logic [1:0] ST_LEN_OVF = 2'd2;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [7:0]  IPAD = 8'h36;
    localparam logic [7:0]  OPAD = 8'h5c;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Byte source selection for the block buffer.
    typedef enum logic [2:0] {
        SRC_IN, SRC_IPAD, SRC_OPAD, SRC_PAD, SRC_ZERO, SRC_LEN, SRC_INNER
    } t_src;

    // Controller to datapath commands.
    typedef struct packed {
        logic       init_chain;   // load initial hash values, fill position 0
        logic       put;          // write one byte into the block buffer
        t_src       src;
        logic [5:0] sel;          // key index, length byte or inner digest byte
        logic       round;        // run one compression round
        logic       round_first;  // load working variables from the chain
        logic       round_last;   // fold working variables into the chain
        logic       save_inner;   // copy the chain into the inner digest
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic [5:0] fill_pos;
    } t_dp_status;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

// ===== rtl/hsha_datapath.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 datapath
// Key store, block buffer with message schedule, round unit and chain value.
// ----------------------------------------------------------------------------
module hsha_datapath
    import hsha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [7:0]       i_byte,
    input  logic             i_key_clear,
    input  logic             i_key_we,
    input  logic [5:0]       i_key_addr,
    input  logic [6:0]       i_round_idx,
    input  logic [63:0]      i_bitlen,
    output t_dp_status       o_status,
    output logic [4:0][31:0] o_chain
);

    logic [31:0] r_key [16];
    logic [15:0] r_key_vld;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_inner [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [5:0]  r_fill;

    logic [15:0] n_key_vld;
    logic [31:0] key_word, key_wr, key_rd_word, w_wr;
    logic [7:0]  key_rd;
    logic [7:0]  put_val;
    logic [31:0] inner_w;
    logic [31:0] a_in, b_in, c_in, d_in, e_in;
    logic [31:0] f_val, k_val, t_val, w_new, w_cur;

    // The key is held as sixteen words; words not written since the key began read as zero.
    assign key_rd_word = r_key_vld[i_cmd.sel[5:2]] ? r_key[i_cmd.sel[5:2]] : 32'h0;
    assign key_rd      = key_rd_word[8*(3-i_cmd.sel[1:0]) +: 8];
    assign inner_w     = r_inner[i_cmd.sel[4:2]];
    assign key_word    = r_key[i_key_addr[5:2]];

    always_comb begin
        if (i_key_addr[1:0] == 2'd0) begin
            key_wr = {i_byte, 24'h0};
        end else begin
            key_wr = key_word;
            key_wr[8*(3-i_key_addr[1:0]) +: 8] = i_byte;
        end
        n_key_vld = i_key_clear ? 16'h0 : r_key_vld;
        if (i_key_we) n_key_vld[i_key_addr[5:2]] = 1'b1;
    end

    always_comb begin
        case (i_cmd.src)
            SRC_IN:    put_val = i_byte;
            SRC_IPAD:  put_val = key_rd ^ IPAD;
            SRC_OPAD:  put_val = key_rd ^ OPAD;
            SRC_PAD:   put_val = PAD_BYTE;
            SRC_LEN:   put_val = i_bitlen[8*(7-i_cmd.sel[2:0]) +: 8];
            SRC_INNER: put_val = inner_w[8*(3-i_cmd.sel[1:0]) +: 8];
            default:   put_val = 8'h00;
        endcase
        if (r_fill[1:0] == 2'd0) begin
            w_wr = {put_val, 24'h0};
        end else begin
            w_wr = r_w[r_fill[5:2]];
            w_wr[8*(3-r_fill[1:0]) +: 8] = put_val;
        end
    end

    // Rolling 16-word schedule: w[0] is the current round's word.
    assign w_new = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign w_cur = r_w[0];

    always_comb begin
        if (i_cmd.round_first) begin
            a_in = r_h[0]; b_in = r_h[1]; c_in = r_h[2]; d_in = r_h[3]; e_in = r_h[4];
        end else begin
            a_in = r_a; b_in = r_b; c_in = r_c; d_in = r_d; e_in = r_e;
        end
        if (i_round_idx < 7'd20) begin
            f_val = (b_in & c_in) | (~b_in & d_in); k_val = K0;
        end else if (i_round_idx < 7'd40) begin
            f_val = b_in ^ c_in ^ d_in; k_val = K1;
        end else if (i_round_idx < 7'd60) begin
            f_val = (b_in & c_in) | (b_in & d_in) | (c_in & d_in); k_val = K2;
        end else begin
            f_val = b_in ^ c_in ^ d_in; k_val = K3;
        end
        t_val = rotl(a_in, 5) + e_in + w_cur + f_val + k_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_vld <= '0;
            r_fill    <= '0;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end else begin
            r_key_vld <= n_key_vld;
            if (i_key_we) r_key[i_key_addr[5:2]] <= key_wr;
            if (i_cmd.init_chain) begin
                r_fill <= '0;
                r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
            end else if (i_cmd.put) begin
                r_w[r_fill[5:2]] <= w_wr;
                r_fill <= r_fill + 6'd1;
            end else if (i_cmd.round) begin
                for (int j = 0; j < 15; j++) r_w[j] <= r_w[j+1];
                r_w[15] <= w_new;
                r_a <= t_val; r_b <= a_in; r_c <= rotl(b_in, 30); r_d <= c_in; r_e <= d_in;
                if (i_cmd.round_last) begin
                    r_h[0] <= r_h[0] + t_val;
                    r_h[1] <= r_h[1] + a_in;
                    r_h[2] <= r_h[2] + rotl(b_in, 30);
                    r_h[3] <= r_h[3] + c_in;
                    r_h[4] <= r_h[4] + d_in;
                end
            end
            if (i_cmd.save_inner) begin
                for (int j = 0; j < 5; j++) r_inner[j] <= r_h[j];
            end
        end
    end

    assign o_status.fill_pos = r_fill;
    assign o_chain = {r_h[4], r_h[3], r_h[2], r_h[1], r_h[0]};

endmodule

// ===== rtl/hsha_ctrl.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 controller
// Sequences key loading, byte absorption, padding, compression and output.
// ----------------------------------------------------------------------------
module hsha_ctrl
    import hsha_pkg::*;
#(
    parameter int LCB = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_hmac_enable,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out,
    output t_cmd             o_cmd,
    output logic [7:0]       o_byte,
    output logic             o_key_clear,
    output logic             o_key_we,
    output logic [5:0]       o_key_addr,
    output logic [6:0]       o_round_idx,
    output logic [63:0]      o_bitlen,
    input  t_dp_status       i_dp,
    input  logic [4:0][31:0] i_chain
);

    typedef enum logic [3:0] {
        S_IDLE, S_IPAD, S_ABSORB, S_PAD80, S_ZERO, S_LEN, S_COMP,
        S_OUTER, S_OPAD, S_INNER, S_OUT
    } t_state;

    localparam logic [LCB-1:0] CMAX    = {LCB{1'b1}};
    localparam logic [LCB-1:0] CNT_ONE = {{(LCB-1){1'b0}}, 1'b1};

    t_state         r_state, r_ret;
    logic           r_key_loading, r_key_ovf, r_len_ovf, r_hmac, r_inner_pass;
    logic           r_hmac_phase_active; // a message is in progress
    logic [6:0]     r_key_cnt;
    logic [LCB-1:0] r_msg_cnt;
    logic [6:0]     r_idx;
    logic [2:0]     r_oidx;
    logic [1:0]     r_stat;
    logic           r_last;
    logic [7:0]     r_byte;

    logic accept;
    logic [63:0] total;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign o_byte     = accept ? i_in.data_byte : r_byte;

    assign total = r_inner_pass ? 64'd84
                 : ({{(64-LCB){1'b0}}, r_msg_cnt} + (r_hmac ? 64'd64 : 64'd0));
    assign o_bitlen    = total << 3;
    assign o_round_idx = r_idx;
    assign o_key_addr  = r_key_loading ? r_key_cnt[5:0] : 6'd0;
    assign o_key_clear = accept && i_in.opcode == OP_KEY && !r_key_loading;
    assign o_key_we    = accept && i_in.opcode == OP_KEY
                       && (!r_key_loading || r_key_cnt < 7'd64);

    assign o_out_valid         = (r_state == S_OUT);
    assign o_out.digest_word   = (r_stat != ST_OK) ? 32'h0 : i_chain[r_oidx];
    assign o_out.word_index    = r_oidx;
    assign o_out.status        = r_stat;
    assign o_out.final_word    = (r_oidx == 3'd4);

    always_comb begin
        o_cmd = '0;
        o_cmd.sel = r_idx[5:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in.opcode == OP_MSG) begin
                    if (!r_hmac_phase_active) o_cmd.init_chain = 1'b1;
                    else begin o_cmd.put = 1'b1; o_cmd.src = SRC_IN; end
                end
            end
            S_ABSORB: begin o_cmd.put = 1'b1; o_cmd.src = SRC_IN; end
            S_IPAD:   begin o_cmd.put = 1'b1; o_cmd.src = SRC_IPAD; end
            S_OPAD:   begin o_cmd.put = 1'b1; o_cmd.src = SRC_OPAD; end
            S_INNER:  begin o_cmd.put = 1'b1; o_cmd.src = SRC_INNER; end
            S_PAD80:  begin o_cmd.put = 1'b1; o_cmd.src = SRC_PAD; end
            S_ZERO:   begin o_cmd.put = 1'b1; o_cmd.src = SRC_ZERO; end
            S_LEN:    begin o_cmd.put = 1'b1; o_cmd.src = SRC_LEN; end
            S_OUTER:  begin o_cmd.init_chain = 1'b1; o_cmd.save_inner = 1'b1; end
            S_COMP:   begin
                o_cmd.round       = 1'b1;
                o_cmd.round_first = (r_idx == 7'd0);
                o_cmd.round_last  = (r_idx == 7'd79);
            end
            S_OUT:    ;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= S_IDLE;
            r_key_loading <= 1'b0; r_key_ovf <= 1'b0; r_key_cnt <= '0;
            r_len_ovf <= 1'b0; r_msg_cnt <= '0; r_hmac <= 1'b0;
            r_inner_pass <= 1'b0; r_hmac_phase_active <= 1'b0;
            r_idx <= '0; r_oidx <= '0; r_stat <= ST_OK; r_last <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_byte <= i_in.data_byte;
                        r_last <= i_in.last;
                        r_idx  <= '0;
                        if (i_in.opcode == OP_KEY) begin
                            r_hmac_phase_active <= 1'b0;
                            if (!r_key_loading) begin
                                r_key_cnt <= 7'd1; r_key_ovf <= 1'b0;
                            end else if (r_key_cnt < 7'd64) begin
                                r_key_cnt <= r_key_cnt + 7'd1;
                            end else r_key_ovf <= 1'b1;
                            r_key_loading <= !i_in.last;
                        end else begin
                            r_key_loading <= 1'b0;
                            if (!r_hmac_phase_active) begin
                                r_hmac_phase_active <= 1'b1;
                                r_hmac <= i_hmac_enable;
                                r_inner_pass <= 1'b0;
                                r_msg_cnt <= CNT_ONE;
                                r_len_ovf <= 1'b0;
                                r_state <= i_hmac_enable ? S_IPAD : S_ABSORB;
                            end else begin
                                if (r_msg_cnt == CMAX) r_len_ovf <= 1'b1;
                                else r_msg_cnt <= r_msg_cnt + CNT_ONE;
                                if (i_dp.fill_pos == 6'd63) begin
                                    r_state <= S_COMP;
                                    r_ret <= i_in.last ? S_PAD80 : S_IDLE;
                                end else if (i_in.last) r_state <= S_PAD80;
                            end
                        end
                    end
                end
                S_IPAD, S_OPAD: begin
                    if (r_idx == 7'd63) begin
                        r_idx <= '0; r_state <= S_COMP;
                        r_ret <= (r_state == S_IPAD) ? S_ABSORB : S_INNER;
                    end else r_idx <= r_idx + 7'd1;
                end
                S_ABSORB: begin
                    if (i_dp.fill_pos == 6'd63) begin
                        r_state <= S_COMP;
                        r_ret <= r_last ? S_PAD80 : S_IDLE;
                    end else r_state <= r_last ? S_PAD80 : S_IDLE;
                end
                S_INNER: begin
                    if (r_idx == 7'd19) begin
                        r_idx <= '0; r_state <= S_PAD80;
                    end else r_idx <= r_idx + 7'd1;
                end
                S_PAD80: begin
                    if (i_dp.fill_pos == 6'd63) begin
                        r_state <= S_COMP; r_ret <= S_ZERO;
                    end else r_state <= (i_dp.fill_pos == 6'd55) ? S_LEN : S_ZERO;
                end
                S_ZERO: begin
                    if (i_dp.fill_pos == 6'd63) begin
                        r_state <= S_COMP; r_ret <= S_ZERO;
                    end else if (i_dp.fill_pos == 6'd55) begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    if (r_idx == 7'd7) begin
                        r_idx <= '0; r_state <= S_COMP;
                        r_ret <= (r_hmac && !r_inner_pass) ? S_OUTER : S_OUT;
                    end else r_idx <= r_idx + 7'd1;
                end
                S_OUTER: begin
                    r_state <= S_OPAD; r_inner_pass <= 1'b1;
                end
                S_COMP: begin
                    if (r_idx == 7'd79) begin
                        r_idx <= '0;
                        r_state <= r_ret;
                        if (r_ret == S_OUT) begin
                            r_oidx <= '0;
                            r_hmac_phase_active <= 1'b0;
                            r_stat <= (r_hmac && r_key_ovf) ? ST_KEY_LONG
                                    : (r_len_ovf ? ST_LEN_OVF : ST_OK);
                        end
                    end else r_idx <= r_idx + 7'd1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        if (r_oidx == 3'd4) begin
                            r_oidx <= '0; r_state <= S_IDLE;
                        end else r_oidx <= r_oidx + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_oidx <= 3'd4)
        else $error("word index beyond digest");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted during output");
    a_round_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMP |-> r_idx < 7'd80)
        else $error("round index overrun");

endmodule

// ===== rtl/hmac_sha1_engine.sv =====
// ----------------------------------------------------------------------------
// HMAC-SHA1 engine top level
// Byte-streaming SHA-1 and HMAC-SHA1 with a 64-byte key store.
//
// Channel   Direction  Beat
// in        input      opcode, data_byte, last
// out       output     digest_word, word_index, status, final_word
// cfg       input      hmac_enable
//
// Message bytes enter the block buffer as they are accepted, the first after the chain is set up.
// Each full block is compressed before the next byte is taken. HMAC first absorbs and compresses
// the key block and ends with an outer pass; after the final byte come padding and the last compression.
// Five result beats leave at one per cycle while the consumer is ready.
// Reset is synchronous; no input beat is taken while results are pending.
// ----------------------------------------------------------------------------
module hmac_sha1_engine
    import hsha_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out
);

    logic             r_hmac_enable;
    t_cmd             cmd;
    t_dp_status       dp;
    logic [7:0]       byte_val;
    logic             key_clear, key_we;
    logic [5:0]       key_addr;
    logic [6:0]       round_idx;
    logic [63:0]      bitlen;
    logic [4:0][31:0] chain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_hmac_enable <= 1'b0;
        else if (i_cfg_we) r_hmac_enable <= i_cfg_data;
    end

    hsha_ctrl #(.LCB(LENGTH_COUNTER_BITS)) u_ctrl (
        .i_clk, .i_rst_n, .i_hmac_enable(r_hmac_enable),
        .i_in_valid, .o_in_ready, .i_in, .o_out_valid, .i_out_ready, .o_out,
        .o_cmd(cmd), .o_byte(byte_val), .o_key_clear(key_clear), .o_key_we(key_we),
        .o_key_addr(key_addr), .o_round_idx(round_idx), .o_bitlen(bitlen),
        .i_dp(dp), .i_chain(chain)
    );

    hsha_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_byte(byte_val), .i_key_clear(key_clear),
        .i_key_we(key_we), .i_key_addr(key_addr), .i_round_idx(round_idx),
        .i_bitlen(bitlen), .o_status(dp), .o_chain(chain)
    );

endmodule
